/* rtl/tst_pkg.sv */
package tst_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HINT_W = $clog2(SLOTS + 1);

  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_EXIT    = 3'd1;
  localparam logic [2:0] CMD_SETST   = 3'd2;
  localparam logic [2:0] CMD_DELIVER = 3'd3;
  localparam logic [2:0] CMD_TAKE    = 3'd4;
  localparam logic [2:0] CMD_SETCUR  = 3'd5;
  localparam logic [2:0] CMD_QUERY   = 3'd6;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [31:0]        entry_handle;
    logic [3:0]         slot;
    logic [1:0]         new_state;
    logic signed [31:0] message;
    logic [4:0]         sender;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic [4:0]         pid;
    logic [1:0]         slot_state;
    logic [31:0]        entry_out;
    logic signed [31:0] message_out;
    logic [4:0]         sender_out;
    logic [3:0]         current_out;
  } out_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
  } ctl_t;

  typedef struct packed {
    logic alloc_go;
    logic hit;
    logic last;
  } status_t;

endpackage

/* rtl/tst_ctrl.sv */
module tst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tst_pkg::status_t status,
  output tst_pkg::ctl_t    ctl,
  output logic             busy,
  output logic             strobe
);
  import tst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    strobe     = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = status.alloc_go ? S_SCAN : S_RESP;
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (status.hit || status.last) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        strobe     = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/tst_dp.sv */
module tst_dp (
  input  logic             clk,
  input  logic             rst,
  input  tst_pkg::in_t     request,
  input  tst_pkg::ctl_t    ctl,
  output tst_pkg::status_t status,
  output tst_pkg::out_t    result
);
  import tst_pkg::*;

  in_t               req;
  out_t              res;
  logic [1:0]        state_r [SLOTS];
  logic [31:0]       entry_r [SLOTS];
  logic [31:0]       mbox_word [SLOTS];
  logic [4:0]        mbox_sender [SLOTS];
  logic [SLOTS-1:0]  mbox_full;
  logic [SLOT_W-1:0] cur;
  logic [HINT_W-1:0] hint;
  logic [SLOT_W-1:0] scan_idx;
  logic [SLOT_W-1:0] scan_cnt;

  logic [SLOT_W-1:0] sidx;
  logic              valid;

  assign sidx            = SLOT_W'(req.slot);
  assign valid           = 32'(req.slot) < SLOTS;
  assign status.alloc_go = (req.cmd == CMD_ALLOC) && (req.entry_handle != 32'd0);
  assign status.hit      = state_r[scan_idx] == ST_FREE;
  assign status.last     = scan_cnt == SLOT_W'(SLOTS - 2);
  assign result          = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        state_r[i]     <= (i == 0) ? ST_READY : ST_FREE;
        entry_r[i]     <= '0;
        mbox_word[i]   <= '0;
        mbox_sender[i] <= '0;
      end
      mbox_full <= '0;
      cur       <= '0;
      hint      <= HINT_W'(1);
    end else begin
      if (ctl.load) begin
        req      <= request;
        scan_cnt <= '0;
        if (32'(hint) >= SLOTS) begin
          scan_idx <= SLOT_W'(1);
        end else begin
          scan_idx <= SLOT_W'(hint);
        end
      end
      if (ctl.exec) begin
        res             <= '0;
        res.current_out <= 4'(cur);
        case (req.cmd)
          CMD_EXIT: begin
            if (cur != '0) begin
              state_r[cur]    <= ST_FREE;
              entry_r[cur]    <= '0;
              mbox_full[cur]  <= 1'b0;
              cur             <= '0;
              res.ok          <= 1'b1;
              res.current_out <= '0;
            end
          end
          CMD_SETST: begin
            if (valid) begin
              state_r[sidx] <= req.new_state;
              res.ok        <= 1'b1;
            end
          end
          CMD_DELIVER: begin
            if (valid && !mbox_full[sidx]) begin
              mbox_word[sidx]   <= req.message;
              mbox_sender[sidx] <= req.sender;
              mbox_full[sidx]   <= 1'b1;
              res.ok            <= 1'b1;
            end
          end
          CMD_TAKE: begin
            if (valid && mbox_full[sidx]) begin
              mbox_full[sidx] <= 1'b0;
              res.message_out <= mbox_word[sidx];
              res.sender_out  <= mbox_sender[sidx];
              res.ok          <= 1'b1;
            end
          end
          CMD_SETCUR: begin
            if (valid) begin
              cur             <= sidx;
              res.current_out <= req.slot;
              res.ok          <= 1'b1;
            end
          end
          CMD_QUERY: begin
            if (valid) begin
              res.slot_state <= state_r[sidx];
              res.entry_out  <= entry_r[sidx];
              res.ok         <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if (ctl.scan) begin
        if (status.hit) begin
          state_r[scan_idx]     <= ST_READY;
          entry_r[scan_idx]     <= req.entry_handle;
          mbox_word[scan_idx]   <= '0;
          mbox_sender[scan_idx] <= '0;
          mbox_full[scan_idx]   <= 1'b0;
          hint                  <= HINT_W'(32'(scan_idx) + 1);
          res.ok                <= 1'b1;
          res.pid               <= 5'(32'(scan_idx) + 1);
        end else if (status.last) begin
          res.ok  <= 1'b0;
          res.pid <= '0;
        end else begin
          scan_cnt <= scan_cnt + SLOT_W'(1);
          if (32'(scan_idx) == SLOTS - 1) begin
            scan_idx <= SLOT_W'(1);
          end else begin
            scan_idx <= scan_idx + SLOT_W'(1);
          end
        end
      end
    end
  end

endmodule

/* rtl/task_slot_table_with_mailboxes_top.sv */
// Task slot table with one-word mailboxes.
// A command word is taken on request at a clock edge where start is high and
// busy is low. Busy stays high until the result word has been shown.
// Each command gives exactly one result word on result, valid for the single
// cycle in which strobe is high; the receiver cannot hold it off and must
// take it in that cycle.
// Most commands pass through the execute state and show their result in the
// response state; busy falls in the cycle after the strobe.
// Allocate with a nonzero entry walks the slots one per cycle, starting at
// the next-fit hint and skipping slot 0, and stops at the first free slot;
// with no free slot it fails after it has tried every slot but slot 0.
// That slot walk in the datapath makes allocation the longest command.
// A synchronous reset returns slot 0 to ready, frees all other slots, clears
// all entries and mailboxes, sets the current slot to 0 and the hint to 1.
// The block is ready for a command as soon as reset is released.
module task_slot_table_with_mailboxes_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tst_pkg::in_t  request,
  output logic          strobe,
  output tst_pkg::out_t result
);
  import tst_pkg::*;

  ctl_t    ctl;
  status_t status;

  tst_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctl    (ctl),
    .busy   (busy),
    .strobe (strobe)
  );

  tst_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .ctl     (ctl),
    .status  (status),
    .result  (result)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after a command was taken");

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result shown while idle");

  a_strobe_free: assert property (@(posedge clk) disable iff (rst)
    strobe |=> (!busy && !strobe))
    else $error("block not idle after its result");

  a_fail_pid: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.ok) |-> (result.pid == 5'd0))
    else $error("failed command carries a pid");

endmodule
